>>> design/sgca_pkg.sv
// Shared types and constants for the saturating grid count accumulator.
// Holds the grid and overflow table sizes, the status and register codes, and the FSM type.
// Used by the accumulator unit and the testbench through scoped names; it depends on nothing.
package sgca_pkg;

  localparam int GRID_SIDE   = 256;
  localparam int GRID_W      = $clog2(GRID_SIDE);
  localparam int SIDE_W      = 9;
  localparam int CELL_AW     = 2 * GRID_W;
  localparam int CELL_DEPTH  = 1 << CELL_AW;
  localparam int CUR_W       = CELL_AW + 1;
  localparam int OVF_ENTRIES = 64;
  localparam int OVF_AW      = $clog2(OVF_ENTRIES);
  localparam int OVF_CW      = OVF_AW + 1;
  localparam int CELL_W      = 16;
  localparam int TOT_W       = 32;
  localparam int OVF_DW      = CELL_AW + TOT_W;

  localparam logic [CELL_W-1:0] CELL_MAX = '1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [1:0] REG_OFFSET_EN = 2'd0;
  localparam logic [1:0] REG_OFFSET    = 2'd1;
  localparam logic [1:0] REG_SIDE      = 2'd2;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CHK, S_CELL, S_SRCH, S_SHIFT, S_PUT,
    S_DSCAN, S_DCELL, S_DOVF, S_DOVQ, S_RESP
  } fsm_t;

endpackage

>>> design/sgca_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a registered read port.
// Used for the cell store and the overflow table; no package dependencies.
module sgca_ram #(
  parameter int AW = 6,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [1<<AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/saturating_grid_count_accumulator_unit.sv
// Saturating grid count accumulator: 256x256 grid of 16-bit cells plus a sorted 64-entry
// overflow table, each in a registered-read RAM. Depends on sgca_pkg and sgca_ram.
//
// After reset the block sweeps the cell RAM to zero, one cell per cycle; in_ready stays
// low meanwhile, configuration writes are taken. One transaction is worked at a time. An
// add steps through check, cell read and response when the cell does not saturate; a
// saturating add walks the sorted overflow table one entry per cycle (up to 64) and, for a
// new key, shifts the tail up one entry per cycle (up to 63 more). A drain reads one cell
// per cycle until it finds a non-zero unsaturated cell; overflow entries then come out
// through the scan, table read, entry capture and response states. Every transaction
// returns to idle before the next one is taken. The result register lets the next
// transaction be taken while a result still waits on out_ready.
module saturating_grid_count_accumulator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_x_coord,
  input  logic [31:0] in_y_coord,
  input  logic [15:0] in_add_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_entry_valid,
  output logic        out_from_overflow,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_total,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int AW  = sgca_pkg::CELL_AW;
  localparam int OW  = sgca_pkg::OVF_AW;
  localparam int OCW = sgca_pkg::OVF_CW;
  localparam int CW  = sgca_pkg::CUR_W;
  localparam int TW  = sgca_pkg::TOT_W;
  localparam int GW  = sgca_pkg::GRID_W;

  sgca_pkg::fsm_t state_r, state_nxt;

  logic                         cfg_en_r;
  logic [31:0]                  cfg_off_r;
  logic [sgca_pkg::SIDE_W-1:0]  cfg_side_r;

  logic [31:0] x_r, y_r;
  logic [15:0] cnt_r;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [16:0]   sum_r, sum_nxt;
  logic [OCW-1:0] pos_r, pos_nxt, k_r, k_nxt, used_r, used_nxt;
  logic [CW-1:0]  cur_r, cur_nxt;
  logic           phase_r, phase_nxt;
  logic [AW-1:0]  clr_r;

  logic [1:0]    res_st_r, res_st_nxt;
  logic          res_ev_r, res_ev_nxt, res_ovf_r, res_ovf_nxt;
  logic [AW-1:0] res_key_r, res_key_nxt;
  logic [TW-1:0] res_tot_r, res_tot_nxt;

  logic          out_valid_r;
  logic [1:0]    out_st_r;
  logic          out_ev_r, out_ovf_r;
  logic [31:0]   out_x_r, out_y_r, out_tot_r;

  // memory ports
  logic                        c_we, c_re;
  logic [AW-1:0]               c_waddr, c_raddr;
  logic [sgca_pkg::CELL_W-1:0] c_wdata, c_q;
  logic                        o_we, o_re;
  logic [OW-1:0]               o_waddr, o_raddr;
  logic [sgca_pkg::OVF_DW-1:0] o_wdata, o_q;

  sgca_ram #(.AW(AW), .DW(sgca_pkg::CELL_W)) u_cells (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .re(c_re), .raddr(c_raddr), .rdata(c_q)
  );

  sgca_ram #(.AW(OW), .DW(sgca_pkg::OVF_DW)) u_ovf (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .re(o_re), .raddr(o_raddr), .rdata(o_q)
  );

  // shared datapath terms
  logic [31:0]   off_use, x_sub, y_sub;
  logic [sgca_pkg::SIDE_W-1:0] side;
  logic          in_range, cell_ok, key_lt, key_eq, ins_full, ins_shift, load_out;
  logic [AW-1:0] idx_w, o_key;
  logic [TW-1:0] o_tot, tot_new;
  logic [TW:0]   tot_sum;
  logic [16:0]   sum_w;
  logic [OCW-1:0] pos_inc, k_dec;
  logic [CW-1:0]  cur_inc;
  logic           cell_live;

  assign off_use   = cfg_en_r ? cfg_off_r : 32'd0;
  assign x_sub     = x_r - off_use;
  assign y_sub     = y_r - off_use;
  assign side      = (cfg_side_r > sgca_pkg::SIDE_W'(sgca_pkg::GRID_SIDE))
                     ? sgca_pkg::SIDE_W'(sgca_pkg::GRID_SIDE) : cfg_side_r;
  assign in_range  = (x_sub < {{(32-sgca_pkg::SIDE_W){1'b0}}, side}) &&
                     (y_sub < {{(32-sgca_pkg::SIDE_W){1'b0}}, side});
  assign idx_w     = {x_sub[GW-1:0], y_sub[GW-1:0]};
  assign sum_w     = {1'b0, c_q} + {1'b0, cnt_r};
  assign cell_ok   = (sum_w < {1'b0, sgca_pkg::CELL_MAX}) && (c_q != sgca_pkg::CELL_MAX);
  assign o_key     = o_q[sgca_pkg::OVF_DW-1:TW];
  assign o_tot     = o_q[TW-1:0];
  assign key_lt    = o_key < idx_r;
  assign key_eq    = o_key == idx_r;
  assign tot_sum   = {1'b0, o_tot} + {{(TW+1-16){1'b0}}, cnt_r};
  assign tot_new   = tot_sum[TW] ? '1 : tot_sum[TW-1:0];
  assign pos_inc   = pos_r + 1'b1;
  assign k_dec     = k_r - 1'b1;
  assign cur_inc   = cur_r + 1'b1;
  assign cell_live = (c_q != '0) && (c_q != sgca_pkg::CELL_MAX);
  assign ins_full  = used_r == OCW'(sgca_pkg::OVF_ENTRIES);
  assign load_out  = (state_r == sgca_pkg::S_RESP) && (!out_valid_r || out_ready);

  // insertion after a failed search: shift needed when used exceeds the insert point
  always_comb begin
    case (state_r)
      sgca_pkg::S_CELL: ins_shift = used_r != '0;
      sgca_pkg::S_SRCH: ins_shift = key_lt ? 1'b0 : (used_r > pos_r);
      default:          ins_shift = 1'b0;
    endcase
  end

  assign in_ready = state_r == sgca_pkg::S_IDLE;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sgca_pkg::S_CLR:   if (clr_r == '1) state_nxt = sgca_pkg::S_IDLE;
      sgca_pkg::S_IDLE:  if (in_valid) state_nxt = in_kind ? sgca_pkg::S_DSCAN : sgca_pkg::S_CHK;
      sgca_pkg::S_CHK:   state_nxt = in_range ? sgca_pkg::S_CELL : sgca_pkg::S_RESP;
      sgca_pkg::S_CELL: begin
        if (cell_ok) state_nxt = sgca_pkg::S_RESP;
        else if (used_r != '0) state_nxt = sgca_pkg::S_SRCH;
        else state_nxt = sgca_pkg::S_PUT;
      end
      sgca_pkg::S_SRCH: begin
        if (key_lt) begin
          if (pos_inc < used_r) state_nxt = sgca_pkg::S_SRCH;
          else if (ins_full) state_nxt = sgca_pkg::S_RESP;
          else state_nxt = sgca_pkg::S_PUT;
        end else if (key_eq) begin
          state_nxt = sgca_pkg::S_RESP;
        end else if (ins_full) begin
          state_nxt = sgca_pkg::S_RESP;
        end else begin
          state_nxt = ins_shift ? sgca_pkg::S_SHIFT : sgca_pkg::S_PUT;
        end
      end
      sgca_pkg::S_SHIFT: if (k_dec <= pos_r) state_nxt = sgca_pkg::S_PUT;
      sgca_pkg::S_PUT:   state_nxt = sgca_pkg::S_RESP;
      sgca_pkg::S_DSCAN: state_nxt = phase_r ? sgca_pkg::S_DOVF : sgca_pkg::S_DCELL;
      sgca_pkg::S_DCELL: begin
        if (cell_live) state_nxt = sgca_pkg::S_RESP;
        else if (cur_inc == CW'(sgca_pkg::CELL_DEPTH)) state_nxt = sgca_pkg::S_DOVF;
      end
      sgca_pkg::S_DOVF:  state_nxt = (cur_r < CW'(used_r)) ? sgca_pkg::S_DOVQ : sgca_pkg::S_RESP;
      sgca_pkg::S_DOVQ:  state_nxt = sgca_pkg::S_RESP;
      sgca_pkg::S_RESP:  if (!out_valid_r || out_ready) state_nxt = sgca_pkg::S_IDLE;
      default:           state_nxt = sgca_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    idx_nxt = idx_r; sum_nxt = sum_r; pos_nxt = pos_r; k_nxt = k_r;
    used_nxt = used_r; cur_nxt = cur_r; phase_nxt = phase_r;
    res_st_nxt = res_st_r; res_ev_nxt = res_ev_r; res_ovf_nxt = res_ovf_r;
    res_key_nxt = res_key_r; res_tot_nxt = res_tot_r;
    c_we = 1'b0; c_waddr = idx_r; c_wdata = sgca_pkg::CELL_MAX;
    c_re = 1'b0; c_raddr = idx_w;
    o_we = 1'b0; o_waddr = pos_r[OW-1:0]; o_wdata = {idx_r, TW'(sum_r)};
    o_re = 1'b0; o_raddr = '0;
    case (state_r)
      sgca_pkg::S_CLR: begin
        c_we = 1'b1; c_waddr = clr_r; c_wdata = '0;
      end
      sgca_pkg::S_IDLE: begin
        res_st_nxt = sgca_pkg::ST_OK; res_ev_nxt = 1'b0; res_ovf_nxt = 1'b0;
        res_key_nxt = '0; res_tot_nxt = '0;
      end
      sgca_pkg::S_CHK: begin
        idx_nxt = idx_w;
        c_re = in_range;
        if (!in_range) res_st_nxt = sgca_pkg::ST_RANGE;
      end
      sgca_pkg::S_CELL: begin
        sum_nxt = sum_w;
        pos_nxt = '0;
        if (cell_ok) begin
          c_we = 1'b1; c_wdata = sum_w[15:0];
        end else if (used_r != '0) begin
          o_re = 1'b1; o_raddr = '0;
        end
      end
      sgca_pkg::S_SRCH: begin
        if (key_lt) begin
          pos_nxt = pos_inc;
          if (pos_inc < used_r) begin
            o_re = 1'b1; o_raddr = pos_inc[OW-1:0];
          end else if (ins_full) begin
            res_st_nxt = sgca_pkg::ST_FULL;
          end
        end else if (key_eq) begin
          o_we = 1'b1; o_wdata = {idx_r, tot_new};
          c_we = 1'b1;
        end else if (ins_full) begin
          res_st_nxt = sgca_pkg::ST_FULL;
        end else begin
          k_nxt = used_r;
          o_re = 1'b1; o_raddr = k_dec[OW-1:0];
          o_raddr = OW'(used_r - 1'b1);
        end
      end
      sgca_pkg::S_SHIFT: begin
        // move entry k-1 up to k, then fetch the next lower one
        o_we = 1'b1; o_waddr = k_r[OW-1:0]; o_wdata = o_q;
        k_nxt = k_dec;
        o_re = 1'b1; o_raddr = OW'(k_dec - 1'b1);
      end
      sgca_pkg::S_PUT: begin
        o_we = 1'b1;
        used_nxt = used_r + 1'b1;
        c_we = 1'b1;
      end
      sgca_pkg::S_DSCAN: begin
        c_re = ~phase_r; c_raddr = cur_r[AW-1:0];
      end
      sgca_pkg::S_DCELL: begin
        cur_nxt = cur_inc;
        if (cell_live) begin
          res_ev_nxt = 1'b1; res_key_nxt = cur_r[AW-1:0];
          res_tot_nxt = TW'(c_q);
          // last cell returned: the next drain starts on the overflow table
          if (cur_inc == CW'(sgca_pkg::CELL_DEPTH)) begin
            phase_nxt = 1'b1; cur_nxt = '0;
          end
        end else if (cur_inc == CW'(sgca_pkg::CELL_DEPTH)) begin
          phase_nxt = 1'b1; cur_nxt = '0;
        end else begin
          c_re = 1'b1; c_raddr = cur_inc[AW-1:0];
        end
      end
      sgca_pkg::S_DOVF: begin
        if (cur_r < CW'(used_r)) begin
          o_re = 1'b1; o_raddr = cur_r[OW-1:0];
        end else begin
          res_st_nxt = sgca_pkg::ST_DONE;
        end
      end
      sgca_pkg::S_DOVQ: begin
        cur_nxt = cur_inc;
        res_ev_nxt = 1'b1; res_ovf_nxt = 1'b1;
        res_key_nxt = o_key; res_tot_nxt = o_tot;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sgca_pkg::S_CLR;
      clr_r       <= '0;
      used_r      <= '0;
      cur_r       <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_en_r    <= 1'b0;
      cfg_off_r   <= '0;
      cfg_side_r  <= sgca_pkg::SIDE_W'(256);
    end else begin
      state_r <= state_nxt;
      if (state_r == sgca_pkg::S_CLR) clr_r <= clr_r + 1'b1;
      used_r  <= used_nxt;
      cur_r   <= cur_nxt;
      phase_r <= phase_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          sgca_pkg::REG_OFFSET_EN: cfg_en_r   <= cfg_wdata[0];
          sgca_pkg::REG_OFFSET:    cfg_off_r  <= cfg_wdata;
          sgca_pkg::REG_SIDE:      cfg_side_r <= cfg_wdata[sgca_pkg::SIDE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r <= in_x_coord; y_r <= in_y_coord; cnt_r <= in_add_count;
    end
    idx_r <= idx_nxt; sum_r <= sum_nxt; pos_r <= pos_nxt; k_r <= k_nxt;
    res_st_r <= res_st_nxt; res_ev_r <= res_ev_nxt; res_ovf_r <= res_ovf_nxt;
    res_key_r <= res_key_nxt; res_tot_r <= res_tot_nxt;
    if (load_out) begin
      out_st_r  <= res_st_r;
      out_ev_r  <= res_ev_r;
      out_ovf_r <= res_ovf_r;
      out_tot_r <= res_tot_r;
      out_x_r   <= res_ev_r ? (32'(res_key_r[AW-1:GW]) + off_use) : 32'd0;
      out_y_r   <= res_ev_r ? (32'(res_key_r[GW-1:0]) + off_use) : 32'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_st_r;
  assign out_entry_valid   = out_ev_r;
  assign out_from_overflow = out_ovf_r;
  assign out_x             = out_x_r;
  assign out_y             = out_y_r;
  assign out_total         = out_tot_r;

  // a new result appears only from the response state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == sgca_pkg::S_RESP))
    else $error("result raised outside response state");

  // the overflow table never holds more than its capacity
  a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= OCW'(sgca_pkg::OVF_ENTRIES))
    else $error("overflow table count past capacity");

  // no transaction is taken during the clearing sweep
  a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sgca_pkg::S_CLR) |-> !in_ready)
    else $error("input taken during cell clear");

  // a drained entry is never flagged together with a non-ok status
  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_entry_valid) |-> (out_status == sgca_pkg::ST_OK))
    else $error("drained entry carries error status");

endmodule

>>> tb/sv/testbench.sv
// Testbench for saturating_grid_count_accumulator_unit: a directed table, then random phases.
// Every result is checked against an in-file predictor of the grid and the overflow table.
// Depends on sgca_pkg and the design sources.
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 300000;

  typedef enum logic [1:0] {OP_ADD, OP_DRAIN, OP_CFG} row_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        entry_valid;
    logic        from_overflow;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] total;
  } hist_result_t;

  typedef struct {
    row_op_t     op;
    logic [31:0] a;       // x coordinate, or register index for a register write
    logic [31:0] b;       // y coordinate, or register value
    logic [15:0] cnt;
    bit          typed;   // status known at a glance
    logic [1:0]  status;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [31:0] in_x_coord = '0;
  logic [31:0] in_y_coord = '0;
  logic [15:0] in_add_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic        out_entry_valid;
  logic        out_from_overflow;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_total;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = sgca_pkg::REG_OFFSET_EN;
  logic [31:0] cfg_wdata = '0;

  saturating_grid_count_accumulator_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state and its copy of the registers
  logic [15:0] cell_cnt [sgca_pkg::GRID_SIDE*sgca_pkg::GRID_SIDE];
  logic [15:0] ovf_key  [sgca_pkg::OVF_ENTRIES];
  logic [31:0] ovf_tot  [sgca_pkg::OVF_ENTRIES];
  int          ovf_n;
  int          scan_pos;
  bit          scan_in_ovf;
  bit          m_offset_en;
  logic [31:0] m_offset;
  logic [8:0]  m_side;

  hist_result_t expected_q[$];
  int  errors;
  bit  quiet;
  int  n_add, n_drain, n_reject, n_full, n_entries, n_done;

  function automatic hist_result_t drained_entry(bit from_ovf, logic [15:0] key,
                                                 logic [31:0] total);
    hist_result_t r;
    logic [31:0] add;
    add = m_offset_en ? m_offset : 32'd0;
    r.status = sgca_pkg::ST_OK;
    r.entry_valid = 1'b1;
    r.from_overflow = from_ovf;
    r.x = {24'd0, key[15:8]} + add;
    r.y = {24'd0, key[7:0]} + add;
    r.total = total;
    return r;
  endfunction

  // Apply one item to the histogram model and return the result it gives
  function automatic hist_result_t predict_histogram(bit kind, logic [31:0] x,
                                                     logic [31:0] y, logic [15:0] cnt);
    hist_result_t r;
    logic [31:0] xx, yy, side;
    logic [15:0] idx, cur;
    logic [16:0] sum;
    int pos;
    r = '0;
    if (!kind) begin
      xx = m_offset_en ? x - m_offset : x;
      yy = m_offset_en ? y - m_offset : y;
      side = (m_side > sgca_pkg::GRID_SIDE) ? sgca_pkg::GRID_SIDE : m_side;
      if (xx >= side || yy >= side) begin
        r.status = sgca_pkg::ST_RANGE;
        return r;
      end
      idx = {xx[7:0], yy[7:0]};
      cur = cell_cnt[idx];
      sum = cur + cnt;
      if (sum < sgca_pkg::CELL_MAX && cur != sgca_pkg::CELL_MAX) begin
        cell_cnt[idx] = sum[15:0];
        return r;
      end
      pos = 0;
      while (pos < ovf_n && ovf_key[pos] < idx) pos++;
      if (pos < ovf_n && ovf_key[pos] == idx) begin
        ovf_tot[pos] = ({1'b0, ovf_tot[pos]} + cnt > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                   : ovf_tot[pos] + cnt;
      end else begin
        if (ovf_n >= sgca_pkg::OVF_ENTRIES) begin
          r.status = sgca_pkg::ST_FULL;
          return r;
        end
        for (int k = ovf_n; k > pos; k--) begin
          ovf_key[k] = ovf_key[k-1];
          ovf_tot[k] = ovf_tot[k-1];
        end
        ovf_key[pos] = idx;
        ovf_tot[pos] = {15'd0, sum};
        ovf_n++;
      end
      cell_cnt[idx] = sgca_pkg::CELL_MAX;
      return r;
    end
    // Drain: unsaturated cells in raster order, then the overflow table
    if (!scan_in_ovf) begin
      while (scan_pos < sgca_pkg::GRID_SIDE*sgca_pkg::GRID_SIDE) begin
        idx = scan_pos[15:0];
        scan_pos++;
        if (cell_cnt[idx] != 0 && cell_cnt[idx] != sgca_pkg::CELL_MAX)
          return drained_entry(1'b0, idx, {16'd0, cell_cnt[idx]});
      end
      scan_in_ovf = 1'b1;
      scan_pos = 0;
    end
    if (scan_pos < ovf_n) begin
      scan_pos++;
      return drained_entry(1'b1, ovf_key[scan_pos-1], ovf_tot[scan_pos-1]);
    end
    r.status = sgca_pkg::ST_DONE;
    return r;
  endfunction

  // Drive one input transaction and hold it until accepted; valid stays high afterwards
  task automatic send_item(bit kind, logic [31:0] x, logic [31:0] y, logic [15:0] cnt,
                           bit typed = 0, logic [1:0] typed_status = sgca_pkg::ST_OK);
    hist_result_t r;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_x_coord <= x;
    in_y_coord <= y;
    in_add_count <= cnt;
    do @(posedge clk); while (!in_ready);
    r = predict_histogram(kind, x, y, cnt);
    if (typed) r.status = typed_status;
    expected_q = {expected_q, r};
    if (kind) n_drain++; else n_add++;
    case (r.status)
      sgca_pkg::ST_RANGE: n_reject++;
      sgca_pkg::ST_FULL:  n_full++;
      sgca_pkg::ST_DONE:  n_done++;
      default:  if (r.entry_valid) n_entries++;
    endcase
  endtask

  // Drop valid and idle for a burst, unless in the quiet tail
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Drain all pending results so the block is idle, then write one register
  task automatic write_reg(logic [1:0] index, logic [31:0] value);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      sgca_pkg::REG_OFFSET_EN: m_offset_en = value[0];
      sgca_pkg::REG_OFFSET:    m_offset = value;
      default:       m_side = value[8:0];
    endcase
  endtask

  task automatic configure(bit en, logic [31:0] off, logic [8:0] side);
    write_reg(sgca_pkg::REG_OFFSET_EN, {31'd0, en});
    write_reg(sgca_pkg::REG_OFFSET, off);
    write_reg(sgca_pkg::REG_SIDE, {23'd0, side});
  endtask

  // Random records, mostly well formed inside a small corner of the grid
  task automatic random_phase(int items, int drain_pct);
    int side_eff;
    logic [31:0] lx, ly, add;
    logic [15:0] cnt;
    int r, rc;
    for (int i = 0; i < items; i++) begin
      side_eff = (m_side > sgca_pkg::GRID_SIDE) ? sgca_pkg::GRID_SIDE : m_side;
      add = m_offset_en ? m_offset : 32'd0;
      r = $urandom_range(0, 99);
      rc = $urandom_range(0, 19);
      cnt = (rc == 0) ? 16'd0 : (rc == 1) ? 16'hFFFF :
            (rc < 6) ? 16'($urandom_range(30000, 65535)) : 16'($urandom_range(1, 400));
      if (r < drain_pct) begin
        send_item(1'b1, $urandom, $urandom, 16'($urandom));
      end else if (r < drain_pct + 10) begin
        send_item(1'b0, $urandom, $urandom, 16'($urandom));
      end else begin
        lx = $urandom_range(0, 3);
        ly = $urandom_range(0, 15);
        if ($urandom_range(0, 9) == 0) lx = side_eff - $urandom_range(0, 1);
        if ($urandom_range(0, 9) == 0) ly = side_eff - $urandom_range(0, 1);
        send_item(1'b0, lx + add, ly + add, cnt);
      end
      if (i == items - 150 && drain_pct != 0) quiet = 1'b1;
      sender_gap();
    end
  endtask

  // Receiver: random stall bursts, none in the quiet tail
  int stall_left;
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(1, 7) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic cmp_field(string f, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, f, e, a);
    end
  endtask

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    hist_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: status %0d", $time, out_status);
      end else begin
        e = expected_q.pop_front();
        cmp_field("status", e.status, out_status);
        cmp_field("entry_valid", e.entry_valid, out_entry_valid);
        cmp_field("from_overflow", e.from_overflow, out_from_overflow);
        cmp_field("out_x", e.x, out_x);
        cmp_field("out_y", e.y, out_y);
        cmp_field("out_total", e.total, out_total);
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel
  int idle_cycles;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results pending", $time, expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  stim_row_t dir_rows[] = '{
    '{OP_ADD, 32'd0, 32'd0, 16'd1, 1, sgca_pkg::ST_OK},
    '{OP_ADD, 32'd0, 32'd0, 16'd0, 1, sgca_pkg::ST_OK},               // zero count
    '{OP_ADD, 32'd256, 32'd0, 16'd5, 1, sgca_pkg::ST_RANGE},
    '{OP_ADD, 32'd0, 32'd256, 16'd5, 1, sgca_pkg::ST_RANGE},
    '{OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, sgca_pkg::ST_RANGE},
    '{OP_ADD, 32'd255, 32'd255, 16'hFFFF, 1, sgca_pkg::ST_OK},        // saturates, new key
    '{OP_ADD, 32'd255, 32'd255, 16'd0, 1, sgca_pkg::ST_OK},           // zero on a saturated cell
    '{OP_ADD, 32'd255, 32'd255, 16'hFFFF, 1, sgca_pkg::ST_OK},        // known key
    '{OP_ADD, 32'd0, 32'd1, 16'hFFFE, 1, sgca_pkg::ST_OK},
    '{OP_ADD, 32'd0, 32'd1, 16'd1, 1, sgca_pkg::ST_OK},               // reaches the ceiling
    '{OP_ADD, 32'd1, 32'd0, 16'hAAAA, 0, sgca_pkg::ST_OK},
    '{OP_ADD, 32'd2, 32'd3, 16'h5555, 0, sgca_pkg::ST_OK},
    '{OP_CFG, sgca_pkg::REG_SIDE, 32'd0, 16'd0, 0, sgca_pkg::ST_OK},  // side zero rejects all
    '{OP_ADD, 32'd0, 32'd0, 16'd3, 1, sgca_pkg::ST_RANGE},
    '{OP_CFG, sgca_pkg::REG_SIDE, 32'd1, 16'd0, 0, sgca_pkg::ST_OK},
    '{OP_ADD, 32'd0, 32'd0, 16'd3, 1, sgca_pkg::ST_OK},
    '{OP_ADD, 32'd1, 32'd0, 16'd3, 1, sgca_pkg::ST_RANGE},
    '{OP_CFG, sgca_pkg::REG_SIDE, 32'd511, 16'd0, 0, sgca_pkg::ST_OK}, // oversize acts as full
    '{OP_ADD, 32'd255, 32'd0, 16'd7, 1, sgca_pkg::ST_OK},
    '{OP_ADD, 32'd0, 32'd256, 16'd7, 1, sgca_pkg::ST_RANGE},
    '{OP_CFG, sgca_pkg::REG_OFFSET, 32'hFFFF_FF00, 16'd0, 0, sgca_pkg::ST_OK},
    '{OP_CFG, sgca_pkg::REG_OFFSET_EN, 32'd1, 16'd0, 0, sgca_pkg::ST_OK},
    '{OP_ADD, 32'hFFFF_FF05, 32'hFFFF_FF07, 16'd9, 1, sgca_pkg::ST_OK},
    '{OP_ADD, 32'h0000_0010, 32'hFFFF_FF00, 16'd1, 1, sgca_pkg::ST_RANGE}  // offset underflow
  };

  initial begin
    m_offset_en = 1'b0;
    m_offset = '0;
    m_side = 9'd256;
    ovf_n = 0;
    scan_pos = 0;
    scan_in_ovf = 1'b0;
    foreach (cell_cnt[i]) cell_cnt[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == OP_CFG) begin
        write_reg(dir_rows[i].a[1:0], dir_rows[i].b);
      end else begin
        send_item(dir_rows[i].op == OP_DRAIN, dir_rows[i].a, dir_rows[i].b,
                  dir_rows[i].cnt, dir_rows[i].typed, dir_rows[i].status);
        sender_gap();
      end
    end

    // Random phases across register settings; drains only in the last one
    configure(1'b0, 32'd0, 9'd256);
    random_phase(350, 0);
    configure(1'b1, $urandom, 9'($urandom_range(1, 8)));
    random_phase(300, 0);
    configure(1'b1, 32'hFFFF_FFFF, 9'd0);
    random_phase(40, 0);
    configure(1'b0, $urandom, 9'd300);
    random_phase(300, 0);
    configure(1'b1, $urandom, 9'd256);
    random_phase(700, 25);

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d adds (%0d out of range, %0d table full) and %0d drains",
             n_add, n_reject, n_full, n_drain);
    $display("Drains returned %0d entries and %0d end-of-drain results; %0d overflow keys",
             n_entries, n_done, ovf_n);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
